// ===== rtl/piecewise_linear_membership_table_top_defines.svh =====
// Assertion macros for the membership table block
`ifndef PIECEWISE_LINEAR_MEMBERSHIP_TABLE_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_MEMBERSHIP_TABLE_TOP_DEFINES_SVH

// expr must hold at every edge out of reset
`define PLMT_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("plmt assertion failed");

// cond must hold in the cycle after trig
`define PLMT_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("plmt assertion failed");

`endif

// ===== rtl/plmt_pkg.sv =====
// Types and constants shared by the membership table modules
`timescale 1ns / 1ps
package plmt_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_EVAL   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_CLAMP  = 2'd3;

  localparam logic [15:0] LEVEL_ONE = 16'h8000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] x_value;
    logic [15:0]        level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] degree;
    logic        table_full;
    logic [4:0]  point_count;
  } out_item_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic signed [15:0] x;
    logic [15:0]        lvl;
    logic               lt;
    logic               occ;
  } link_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               ins_go;
    logic               upd_en;
    logic               clamp;
    logic signed [15:0] key;
    logic [15:0]        lvl;
  } cmd_t;

endpackage

// ===== rtl/plmt_cell.sv =====
// One breakpoint slot of the sorted table
`timescale 1ns / 1ps
module plmt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  plmt_pkg::cmd_t  cmd,
  input  plmt_pkg::link_t prev,
  input  logic [CW-1:0]   count,
  output plmt_pkg::link_t cur,
  output logic            eq
);
  import plmt_pkg::*;

  logic signed [15:0] x_r;
  logic [15:0]        lvl_r;
  logic               occ;
  logic               lt;
  logic               take_new;
  logic               take_shift;

  assign occ = count > CW'(IDX);
  assign lt  = occ && (x_r < cmd.key);
  assign eq  = occ && (x_r == cmd.key);

  // new point lands at the first slot not below the key; slots above move up
  assign take_new   = !lt && ((IDX == 0) || prev.lt);
  assign take_shift = !prev.lt && prev.occ;

  assign cur = '{x: x_r, lvl: lvl_r, lt: lt, occ: occ};

  always_ff @(posedge clk) begin
    if (cmd.ins_go) begin
      if (take_new) begin
        x_r   <= cmd.key;
        lvl_r <= cmd.lvl;
      end else if (take_shift) begin
        x_r   <= prev.x;
        lvl_r <= prev.lvl;
      end
    end else if (cmd.upd_en && eq) begin
      lvl_r <= cmd.lvl;
    end else if (cmd.clamp && (lvl_r > cmd.lvl)) begin
      lvl_r <= cmd.lvl;
    end
  end

endmodule

// ===== rtl/plmt_div.sv =====
// Serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module plmt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [15:0] quot
);
  import plmt_pkg::*;

  logic [17:0] rem;
  logic [15:0] qsh;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;
  logic        fit;

  // quotient is known to fit 16 bits, so the top of num is already below den
  assign trial = {rem[16:0], qsh[15]};
  assign fit   = trial >= {1'b0, den};
  assign quot  = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[33:16];
      qsh <= num[15:0];
    end else if (busy) begin
      rem <= fit ? (trial - {1'b0, den}) : trial;
      qsh <= {qsh[14:0], fit};
    end
  end

endmodule

// ===== rtl/piecewise_linear_membership_table_top.sv =====
// Piecewise-linear membership table: chain of breakpoint cells plus interpolator
`timescale 1ns / 1ps
// One item at a time. Insert, clear and clamp results, and evaluate results
// with no bracket, go from the execute state straight to the output register.
// Interpolated evaluate results go through bracket select, one multiply, a
// divider start cycle, the serial divider, its done cycle and the final add.
// The next item is accepted the cycle after the result is taken. Breakpoints
// live in a row of MAX_POINTS cells; an insert shifts every cell above the
// slot one place at once. Results sit in an output register until taken.
module piecewise_linear_membership_table_top #(
  parameter int MAX_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  plmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plmt_pkg::out_item_t out_data
);
  import plmt_pkg::*;
  `include "piecewise_linear_membership_table_top_defines.svh"

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_LOAD = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state;
  logic [1:0]         req_q;
  logic signed [15:0] key_q;
  logic [15:0]        lvl_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;

  logic signed [15:0] lo_x, hi_x;
  logic [15:0]        lo_l, hi_l;
  logic signed [33:0] prod;
  logic [16:0]        span;
  logic               div_go;
  logic               div_done;
  logic [15:0]        div_q;

  link_t              lk [0:MAX_POINTS];
  logic [MAX_POINTS-1:0] eq_v;
  logic [MAX_POINTS:0]   lt_ext;
  cmd_t               cmd;

  logic               accept;
  logic               any_eq;
  logic               is_full;
  logic               lo_found, hi_found;
  logic signed [15:0] lo_x_c, hi_x_c;
  logic [15:0]        lo_l_c, hi_l_c;
  logic [15:0]        deg_exec;
  logic [31:0]        cnt_ext;
  logic signed [16:0] dx, dl;
  logic [33:0]        mag;
  logic signed [17:0] deg_sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;

  assign lk[0] = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      plmt_cell #(.IDX(g), .CW(CW)) u_cell (
        .clk  (clk),
        .cmd  (cmd),
        .prev (lk[g]),
        .count(count),
        .cur  (lk[g+1]),
        .eq   (eq_v[g])
      );
      assign lt_ext[g] = lk[g+1].lt;
    end
  endgenerate
  assign lt_ext[MAX_POINTS] = 1'b0;

  assign any_eq  = |eq_v;
  assign is_full = count == CW'(MAX_POINTS);

  always_comb begin
    cmd = '0;
    cmd.key = key_q;
    cmd.lvl = lvl_q;
    if (state == S_EXEC) begin
      cmd.ins_go = (req_q == REQ_INSERT) && !any_eq && !is_full;
      cmd.upd_en = (req_q == REQ_INSERT) && any_eq;
      cmd.clamp  = req_q == REQ_CLAMP;
    end
  end

  // bracket: lo is the last cell below the key, hi the first cell after it
  always_comb begin
    lo_found = 1'b0;
    hi_found = 1'b0;
    lo_x_c   = '0;
    hi_x_c   = '0;
    lo_l_c   = '0;
    hi_l_c   = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) begin
        lo_found = 1'b1;
        lo_x_c   = lo_x_c | lk[i+1].x;
        lo_l_c   = lo_l_c | lk[i+1].lvl;
      end
      if (!lt_ext[i] && lk[i].lt && lk[i+1].occ) begin
        hi_found = 1'b1;
        hi_x_c   = hi_x_c | lk[i+1].x;
        hi_l_c   = hi_l_c | lk[i+1].lvl;
      end
    end
  end

  // count after the request in S_EXEC
  always_comb begin
    count_next = count;
    if (req_q == REQ_CLEAR) begin
      count_next = '0;
    end else if (cmd.ins_go) begin
      count_next = count + CW'(1);
    end
  end

  // end values outside the range; interpolated results overwrite this later
  always_comb begin
    deg_exec = '0;
    if (req_q == REQ_EVAL && count != '0) begin
      deg_exec = lo_found ? lo_l_c : lk[1].lvl;
    end
  end

  assign cnt_ext = 32'(count_next);
  assign dx      = 17'(key_q) - 17'(lo_x);
  assign dl      = $signed({1'b0, hi_l}) - $signed({1'b0, lo_l});
  assign mag     = prod[33] ? 34'(-prod) : 34'(prod);
  assign deg_sum = $signed({2'b00, lo_l}) +
                   (prod[33] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q}));

  plmt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (mag),
    .den  (span),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) state <= S_EXEC;
        S_EXEC: begin
          if (req_q == REQ_EVAL && count != '0 && lo_found && hi_found) begin
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
          count <= count_next;
        end
        S_MUL: begin
          state  <= S_DIV;
          div_go <= 1'b1;
        end
        S_DIV:  if (div_done) state <= S_LOAD;
        S_LOAD: state <= S_OUT;
        S_OUT:  if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= in_data.req_type;
      key_q <= in_data.x_value;
      lvl_q <= (in_data.level > LEVEL_ONE) ? LEVEL_ONE : in_data.level;
    end
    if (state == S_EXEC) begin
      lo_x <= lo_x_c;
      lo_l <= lo_l_c;
      hi_x <= hi_x_c;
      hi_l <= hi_l_c;
      out_data.degree      <= deg_exec;
      out_data.table_full  <= (req_q == REQ_INSERT) && !any_eq && is_full;
      out_data.point_count <= 5'(cnt_ext);
    end
    if (state == S_MUL) begin
      prod <= dx * dl;
      span <= 17'(hi_x) - 17'(lo_x);
    end
    if (state == S_LOAD) out_data.degree <= deg_sum[15:0];
  end

  `PLMT_ASSERT(a_count_range, count <= CW'(MAX_POINTS))
  `PLMT_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC)
  `PLMT_ASSERT(a_div_done_state, !div_done || state == S_DIV)
  `PLMT_ASSERT_NEXT(a_full_no_grow, state == S_EXEC && is_full, count <= CW'(MAX_POINTS))

endmodule

// ===== sim/testbench.sv =====
// Testbench for the piecewise-linear membership table: directed table plus random requests
`timescale 1ns / 1ps
module testbench;
  import plmt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  piecewise_linear_membership_table_top #(.MAX_POINTS(TABLE_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] bp_x [TABLE_DEPTH];
  logic [15:0] bp_lvl [TABLE_DEPTH];
  int bp_count;

  out_item_t pending_results[$];
  int mismatches;
  int idle_count;
  bit quiet_sides;

  // directed rows: request plus optional typed-in result
  typedef struct {
    in_item_t req;
    bit known;
    out_item_t res;
  } stim_row_t;
  stim_row_t stim_rows[$];

  function automatic logic [15:0] sat_level(logic [15:0] v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

  function automatic int slot_for(logic signed [15:0] x);
    int i;
    i = 0;
    while (i < bp_count && bp_x[i] < x) i++;
    return i;
  endfunction

  function automatic logic [15:0] interp_level(logic signed [15:0] x);
    int hi;
    longint lp, li, dx, span;
    if (bp_count == 0) return '0;
    if (bp_count == 1 || x <= bp_x[0]) return bp_lvl[0];
    if (x >= bp_x[bp_count-1]) return bp_lvl[bp_count-1];
    hi = slot_for(x);
    span = longint'(bp_x[hi]) - longint'(bp_x[hi-1]);
    lp = bp_lvl[hi-1];
    li = bp_lvl[hi];
    dx = longint'(x) - longint'(bp_x[hi-1]);
    return 16'(lp + (dx * (li - lp)) / span);
  endfunction

  function automatic out_item_t apply_request(in_item_t r);
    out_item_t o;
    logic [15:0] lv;
    int pos;
    o = '0;
    lv = sat_level(r.level);
    case (r.req_type)
      REQ_INSERT: begin
        pos = slot_for(r.x_value);
        if (pos < bp_count && bp_x[pos] == r.x_value) begin
          bp_lvl[pos] = lv;
        end else if (bp_count >= TABLE_DEPTH) begin
          o.table_full = 1'b1;
        end else begin
          for (int k = bp_count; k > pos; k--) begin
            bp_x[k] = bp_x[k-1];
            bp_lvl[k] = bp_lvl[k-1];
          end
          bp_x[pos] = r.x_value;
          bp_lvl[pos] = lv;
          bp_count++;
        end
      end
      REQ_EVAL: o.degree = interp_level(r.x_value);
      REQ_CLEAR: bp_count = 0;
      default: begin
        for (int i = 0; i < bp_count; i++)
          if (bp_lvl[i] > lv) bp_lvl[i] = lv;
      end
    endcase
    o.point_count = 5'(bp_count);
    return o;
  endfunction

  function automatic in_item_t mk_req(logic [1:0] t, int x, int lv);
    in_item_t r;
    r.req_type = t;
    r.x_value = 16'(x);
    r.level = 16'(lv);
    return r;
  endfunction

  function automatic out_item_t mk_res(int d, bit f, int c);
    out_item_t o;
    o.degree = 16'(d);
    o.table_full = f;
    o.point_count = 5'(c);
    return o;
  endfunction

  task automatic add_row(in_item_t r, bit known, out_item_t o);
    stim_row_t s;
    s.req = r;
    s.known = known;
    s.res = o;
    stim_rows = {stim_rows, s};
  endtask

  // random request, mostly inserts and evaluates, mostly on a narrow x range to reach full tables
  function automatic in_item_t random_request();
    in_item_t r;
    int sel;
    sel = $urandom_range(99);
    r.x_value = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40) - 20);
    r.level = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    if (sel < 45) r.req_type = REQ_INSERT;
    else if (sel < 88) r.req_type = REQ_EVAL;
    else if (sel < 93) r.req_type = REQ_CLEAR;
    else r.req_type = REQ_CLAMP;
    return r;
  endfunction

  // valid stays high after an accept until the next item or an idle cycle
  task automatic send_request(in_item_t r, bit known, out_item_t typed);
    out_item_t predicted;
    while (!quiet_sides && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(r);
    if (known && predicted != typed) begin
      // table entry disagrees with the predictor; trust the typed value
      predicted = typed;
    end
    pending_results = {pending_results, predicted};
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data.degree !== exp_res.degree ||
              out_data.table_full !== exp_res.table_full ||
              out_data.point_count !== exp_res.point_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected deg=%0d full=%0d cnt=%0d got deg=%0d full=%0d cnt=%0d",
                       exp_res.degree, exp_res.table_full, exp_res.point_count,
                       out_data.degree, out_data.table_full, out_data.point_count);
          end
        end
      end
      out_stall <= quiet_sides ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_count = 0;
    quiet_sides = 1'b0;
    bp_count = 0;
    // directed rows
    add_row(mk_req(REQ_EVAL, 0, 0), 1, mk_res(0, 0, 0));
    add_row(mk_req(REQ_CLEAR, 0, 0), 1, mk_res(0, 0, 0));
    add_row(mk_req(REQ_CLAMP, 0, 100), 1, mk_res(0, 0, 0));
    add_row(mk_req(REQ_INSERT, 0, 16'hFFFF), 1, mk_res(0, 0, 1));
    add_row(mk_req(REQ_EVAL, -32768, 0), 1, mk_res(32768, 0, 1));
    add_row(mk_req(REQ_EVAL, 32767, 0), 1, mk_res(32768, 0, 1));
    add_row(mk_req(REQ_INSERT, -32768, 0), 1, mk_res(0, 0, 2));
    add_row(mk_req(REQ_INSERT, 32767, 32768), 1, mk_res(0, 0, 3));
    add_row(mk_req(REQ_EVAL, -32768, 0), 1, mk_res(0, 0, 3));
    add_row(mk_req(REQ_EVAL, 32767, 0), 1, mk_res(32768, 0, 3));
    add_row(mk_req(REQ_EVAL, 0, 0), 1, mk_res(32768, 0, 3));
    add_row(mk_req(REQ_EVAL, -1, 0), 0, '0);
    add_row(mk_req(REQ_EVAL, 12345, 0), 0, '0);
    add_row(mk_req(REQ_CLAMP, 0, 16'hFFFF), 0, '0);
    add_row(mk_req(REQ_CLAMP, 0, 1000), 0, '0);
    add_row(mk_req(REQ_EVAL, -20000, 16'h5555), 0, '0);
    add_row(mk_req(REQ_INSERT, 0, 7), 0, '0);
    add_row(mk_req(REQ_EVAL, 0, 16'hAAAA), 0, '0);
    for (int i = 1; i <= 14; i++) add_row(mk_req(REQ_INSERT, i * 100, i * 2000), 0, '0);
    add_row(mk_req(REQ_INSERT, 50, 500), 1, mk_res(0, 1, 16));
    add_row(mk_req(REQ_INSERT, 100, 123), 1, mk_res(0, 0, 16));
    add_row(mk_req(REQ_EVAL, 150, 0), 0, '0);
    add_row(mk_req(REQ_CLEAR, 0, 0), 1, mk_res(0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].known, stim_rows[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_sides = (n >= 600 && n < 800);
      if (n == 1000) begin
        // hold off until the block has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_request(random_request(), 0, '0);
    end
    quiet_sides = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
